/* rtl/core/assert_macros.svh */
// Assertion wrappers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BCP_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("assertion failed");
`define BCP_ASSERT_ALWAYS(lbl, clk_s, prop) \
    lbl: assert property (@(posedge clk_s) prop) else $error("assertion failed");
`else
`define BCP_ASSERT(lbl, clk_s, rst_s, prop)
`define BCP_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

/* rtl/core/bcp_pkg.sv */
package bcp_pkg;

    localparam int CNT_W      = 16;
    localparam int ANG_W      = 17;
    localparam int GAIN_W     = 32;
    localparam int LIM_W      = 15;
    localparam int DRV_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int FE_W   = 18;
    localparam int SUM_W  = 16;
    localparam int NUM_W  = 21;
    localparam int MAG_W  = 20;
    localparam int MA_W   = GAIN_W;
    localparam int MB_W   = 25;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = PROD_W + 1;

    localparam int SUM_CLAMP = 20000;
    localparam int SPEED_LIM = 32767;
    localparam int FE_MAX    = 98304;

    // x/10 == (x * RECIP10) >> RECIP10_SH for x below 2^22
    localparam logic signed [MA_W-1:0] RECIP10 = 32'sd838861;
    localparam int RECIP10_SH = 23;

    localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_KP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_KD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_KI      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_KP       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_KD       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BALANCE_ANGLE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd7;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_SH8
    } acc_op_t;

    typedef struct packed {
        logic    mul_en;
        acc_op_t acc_op;
    } mac_ctl_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] upright_kp;
        logic signed [GAIN_W-1:0] upright_kd;
        logic signed [GAIN_W-1:0] speed_kp;
        logic signed [GAIN_W-1:0] speed_ki;
        logic signed [GAIN_W-1:0] turn_kp;
        logic signed [GAIN_W-1:0] turn_kd;
        logic signed [ANG_W-1:0]  balance_angle;
        logic        [LIM_W-1:0]  drive_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        upright_kp:    32'sd19660800,
        upright_kd:    32'sd150733,
        speed_kp:      -32'sd32768,
        speed_ki:      -32'sd164,
        turn_kp:       -32'sd1638400,
        turn_kd:       -32'sd98304,
        balance_angle: -17'sd1536,
        drive_limit:   15'd7200
    };

endpackage

/* rtl/core/bcp_if.sv */
interface bcp_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [bcp_pkg::CNT_W-1:0]   count_left;
    logic signed [bcp_pkg::CNT_W-1:0]   count_right;
    logic signed [bcp_pkg::ANG_W-1:0]   roll_angle;
    logic signed [bcp_pkg::CNT_W-1:0]   rate_tilt;
    logic signed [bcp_pkg::CNT_W-1:0]   rate_yaw;
    logic signed [bcp_pkg::CNT_W-1:0]   speed_goal;
    logic signed [bcp_pkg::CNT_W-1:0]   turn_goal;

    modport source (
        output valid, count_left, count_right, roll_angle, rate_tilt, rate_yaw,
               speed_goal, turn_goal,
        input  ready
    );
    modport sink (
        input  valid, count_left, count_right, roll_angle, rate_tilt, rate_yaw,
               speed_goal, turn_goal,
        output ready
    );
endinterface

interface bcp_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [bcp_pkg::DRV_W-1:0]   drive_left;
    logic signed [bcp_pkg::DRV_W-1:0]   drive_right;

    modport source (output valid, drive_left, drive_right, input ready);
    modport sink (input valid, drive_left, drive_right, output ready);
endinterface

interface bcp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bcp_pkg::CFG_IDX_W-1:0]       index;
    logic [bcp_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/bcp_cfg_regs.sv */
module bcp_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    bcp_cfg_if.sink         cfg,
    output bcp_pkg::cfg_t   regs
);

    bcp_pkg::cfg_t cfg_reg;
    bcp_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                bcp_pkg::REG_UPRIGHT_KP:    cfg_next.upright_kp    = cfg.data;
                bcp_pkg::REG_UPRIGHT_KD:    cfg_next.upright_kd    = cfg.data;
                bcp_pkg::REG_SPEED_KP:      cfg_next.speed_kp      = cfg.data;
                bcp_pkg::REG_SPEED_KI:      cfg_next.speed_ki      = cfg.data;
                bcp_pkg::REG_TURN_KP:       cfg_next.turn_kp       = cfg.data;
                bcp_pkg::REG_TURN_KD:       cfg_next.turn_kd       = cfg.data;
                bcp_pkg::REG_BALANCE_ANGLE:
                    cfg_next.balance_angle = cfg.data[bcp_pkg::ANG_W-1:0];
                bcp_pkg::REG_DRIVE_LIMIT:
                    cfg_next.drive_limit = cfg.data[bcp_pkg::LIM_W-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= bcp_pkg::CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

endmodule

/* rtl/core/bcp_mac.sv */
module bcp_mac (
    input  logic                                 clk,
    input  bcp_pkg::mac_ctl_t                    ctl,
    input  logic signed [bcp_pkg::MA_W-1:0]      op_a,
    input  logic signed [bcp_pkg::MB_W-1:0]      op_b,
    output logic signed [bcp_pkg::PROD_W-1:0]    prod,
    output logic signed [bcp_pkg::ACC_W-1:0]     acc
);

    logic signed [bcp_pkg::PROD_W-1:0] prod_reg;
    logic signed [bcp_pkg::PROD_W-1:0] prod_next;
    logic signed [bcp_pkg::ACC_W-1:0]  acc_reg;
    logic signed [bcp_pkg::ACC_W-1:0]  acc_next;
    logic signed [bcp_pkg::ACC_W-1:0]  prod_ext;

    assign prod = prod_reg;
    assign acc  = acc_reg;

    always_comb
    begin
        prod_ext  = {prod_reg[bcp_pkg::PROD_W-1], prod_reg};
        prod_next = ctl.mul_en ? op_a * op_b : prod_reg;
        case (ctl.acc_op)
            bcp_pkg::ACC_LOAD:    acc_next = prod_ext;
            bcp_pkg::ACC_ADD:     acc_next = acc_reg + prod_ext;
            bcp_pkg::ACC_ADD_SH8: acc_next = acc_reg + (prod_ext <<< 8);
            default:              acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

endmodule

/* rtl/core/balance_cascade_pid_step_core.sv */
// Two-wheel balance controller, one control tick per request.
// sensor: valid/ready request carrying wheel counts, roll angle (Q8.8 deg),
//   gyro rates and the speed and turn targets.
// motor: valid/ready request carrying the two saturated motor drives.
// cfg: write-only register port (index, data), always ready. Write only
//   while no tick is in flight and no drive request is pending.
// A tick steps through the sequencer states from S_NUM to S_OUT before
// motor.valid rises, and the core returns to idle before the next accept.
// The states share the single 32x25 multiply-accumulate unit, which carries
// the divide by ten and six gain products in sequence.
// sensor.ready is high only while the sequencer is idle.
// The result sits in an output register; if motor is stalled the next
// tick may still be accepted and runs up to its last step, where it waits
// until the previous drive request is taken.
// Reset restores all gains to their defaults and clears the filtered
// speed error and its integral.
`include "assert_macros.svh"

module balance_cascade_pid_step_core (
    input  logic        clk,
    input  logic        rst_n,
    bcp_in_if.sink      sensor,
    bcp_out_if.source   motor,
    bcp_cfg_if.sink     cfg
);

    localparam int SUMX_W = bcp_pkg::SUM_W + 3;
    localparam int DIFF_W = bcp_pkg::MB_W;
    localparam int UP_W   = 34;
    localparam int SAT_W  = UP_W + 1;

    localparam logic signed [bcp_pkg::ACC_W-1:0] V_HI =
        bcp_pkg::ACC_W'(bcp_pkg::SPEED_LIM);
    localparam logic signed [bcp_pkg::ACC_W-1:0] V_LO = -V_HI;
    localparam logic signed [SUMX_W-1:0] ES_HI = SUMX_W'(bcp_pkg::SUM_CLAMP);
    localparam logic signed [SUMX_W-1:0] ES_LO = -ES_HI;
    localparam logic signed [bcp_pkg::FE_W-1:0] FE_HI =
        bcp_pkg::FE_W'(bcp_pkg::FE_MAX);

    typedef enum logic [4:0] {
        S_IDLE, S_NUM, S_DIV, S_FE, S_M1, S_M2, S_A2, S_V, S_DIFF,
        S_M3, S_M4, S_A4, S_UP, S_M6, S_A6, S_TN, S_OUT
    } st_t;

    function automatic logic signed [bcp_pkg::ACC_W-1:0] trunc_shr(
        input logic signed [bcp_pkg::ACC_W-1:0] x,
        input logic [4:0]                       k
    );
        logic signed [bcp_pkg::ACC_W-1:0] bias;
        bias = x[bcp_pkg::ACC_W-1]
             ? ((bcp_pkg::ACC_W'(1) << k) - bcp_pkg::ACC_W'(1)) : '0;
        return (x + bias) >>> k;
    endfunction

    function automatic logic signed [bcp_pkg::DRV_W-1:0] sat_drive(
        input logic signed [SAT_W-1:0] x,
        input logic signed [SAT_W-1:0] lim
    );
        logic signed [SAT_W-1:0] y;
        y = x;
        if (x > lim)
            y = lim;
        else if (x < -lim)
            y = -lim;
        return y[bcp_pkg::DRV_W-1:0];
    endfunction

    bcp_pkg::cfg_t     regs;
    bcp_pkg::mac_ctl_t mac_ctl;
    logic signed [bcp_pkg::MA_W-1:0]   op_a;
    logic signed [bcp_pkg::MB_W-1:0]   op_b;
    logic signed [bcp_pkg::PROD_W-1:0] prod;
    logic signed [bcp_pkg::ACC_W-1:0]  acc;

    st_t st_reg, st_next;
    logic signed [bcp_pkg::CNT_W-1:0] cl_reg, cl_next;
    logic signed [bcp_pkg::CNT_W-1:0] cr_reg, cr_next;
    logic signed [bcp_pkg::ANG_W-1:0] roll_reg, roll_next;
    logic signed [bcp_pkg::CNT_W-1:0] rtilt_reg, rtilt_next;
    logic signed [bcp_pkg::CNT_W-1:0] ryaw_reg, ryaw_next;
    logic signed [bcp_pkg::CNT_W-1:0] sgoal_reg, sgoal_next;
    logic signed [bcp_pkg::CNT_W-1:0] tgoal_reg, tgoal_next;
    logic signed [bcp_pkg::FE_W-1:0]  fe_reg, fe_next;
    logic signed [bcp_pkg::SUM_W-1:0] esum_reg, esum_next;
    logic                             neg_reg, neg_next;
    logic        [bcp_pkg::MAG_W-1:0] mag_reg, mag_next;
    logic signed [bcp_pkg::CNT_W-1:0] v_reg, v_next;
    logic signed [DIFF_W-1:0]         diff_reg, diff_next;
    logic signed [UP_W-1:0]           up_reg, up_next;
    logic signed [UP_W-1:0]           tn_reg, tn_next;
    logic signed [bcp_pkg::DRV_W-1:0] dl_reg, dl_next;
    logic signed [bcp_pkg::DRV_W-1:0] dr_reg, dr_next;
    logic                             ov_reg, ov_next;

    logic signed [bcp_pkg::FE_W-1:0]  e_w;
    logic signed [bcp_pkg::NUM_W-1:0] num_w;
    logic        [bcp_pkg::FE_W-2:0]  q_w;
    logic signed [bcp_pkg::FE_W-1:0]  f_w;
    logic signed [SUMX_W-1:0]         sum_w;
    logic signed [bcp_pkg::ACC_W-1:0] vt_w;
    logic signed [SAT_W-1:0]          lim_w;
    logic signed [bcp_pkg::DRV_W-1:0] lim16_w;
    logic                             out_free;

    bcp_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    bcp_mac u_mac (
        .clk  (clk),
        .ctl  (mac_ctl),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod),
        .acc  (acc)
    );

    assign sensor.ready      = (st_reg == S_IDLE);
    assign motor.valid       = ov_reg;
    assign motor.drive_left  = dl_reg;
    assign motor.drive_right = dr_reg;
    assign out_free          = !ov_reg || motor.ready;
    assign lim16_w           = $signed({1'b0, regs.drive_limit});
    assign lim_w             = SAT_W'(lim16_w);

    always_comb
    begin
        e_w   = bcp_pkg::FE_W'(cl_reg) + bcp_pkg::FE_W'(cr_reg)
              - bcp_pkg::FE_W'(sgoal_reg);
        num_w = (bcp_pkg::NUM_W'(e_w) <<< 1) + bcp_pkg::NUM_W'(e_w)
              + (bcp_pkg::NUM_W'(fe_reg) <<< 3) - bcp_pkg::NUM_W'(fe_reg);
        q_w   = prod[bcp_pkg::RECIP10_SH + bcp_pkg::FE_W - 2 : bcp_pkg::RECIP10_SH];
        f_w   = neg_reg ? -$signed({1'b0, q_w}) : $signed({1'b0, q_w});
        sum_w = SUMX_W'(esum_reg) + SUMX_W'(f_w);
        vt_w  = trunc_shr(acc, 5'd16);
    end

    always_comb
    begin
        st_next    = st_reg;
        cl_next    = cl_reg;
        cr_next    = cr_reg;
        roll_next  = roll_reg;
        rtilt_next = rtilt_reg;
        ryaw_next  = ryaw_reg;
        sgoal_next = sgoal_reg;
        tgoal_next = tgoal_reg;
        fe_next    = fe_reg;
        esum_next  = esum_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        v_next     = v_reg;
        diff_next  = diff_reg;
        up_next    = up_reg;
        tn_next    = tn_reg;
        dl_next    = dl_reg;
        dr_next    = dr_reg;
        ov_next    = ov_reg && !motor.ready;
        mac_ctl    = '{mul_en: 1'b0, acc_op: bcp_pkg::ACC_HOLD};
        op_a       = regs.speed_kp;
        op_b       = bcp_pkg::MB_W'(fe_reg);

        case (st_reg)
            S_IDLE:
            begin
                if (sensor.valid)
                begin
                    cl_next    = sensor.count_left;
                    cr_next    = sensor.count_right;
                    roll_next  = sensor.roll_angle;
                    rtilt_next = sensor.rate_tilt;
                    ryaw_next  = sensor.rate_yaw;
                    sgoal_next = sensor.speed_goal;
                    tgoal_next = sensor.turn_goal;
                    st_next    = S_NUM;
                end
            end
            S_NUM:
            begin
                neg_next = num_w[bcp_pkg::NUM_W-1];
                mag_next = num_w[bcp_pkg::NUM_W-1] ? bcp_pkg::MAG_W'(-num_w)
                                                   : bcp_pkg::MAG_W'(num_w);
                st_next  = S_DIV;
            end
            S_DIV:
            begin
                mac_ctl.mul_en = 1'b1;
                op_a           = bcp_pkg::RECIP10;
                op_b           = bcp_pkg::MB_W'({1'b0, mag_reg});
                st_next        = S_FE;
            end
            S_FE:
            begin
                fe_next = f_w;
                if (sum_w > ES_HI)
                    esum_next = bcp_pkg::SUM_W'(ES_HI);
                else if (sum_w < ES_LO)
                    esum_next = bcp_pkg::SUM_W'(ES_LO);
                else
                    esum_next = bcp_pkg::SUM_W'(sum_w);
                st_next = S_M1;
            end
            S_M1:
            begin
                mac_ctl.mul_en = 1'b1;
                op_a           = regs.speed_kp;
                op_b           = bcp_pkg::MB_W'(fe_reg);
                st_next        = S_M2;
            end
            S_M2:
            begin
                mac_ctl = '{mul_en: 1'b1, acc_op: bcp_pkg::ACC_LOAD};
                op_a    = regs.speed_ki;
                op_b    = bcp_pkg::MB_W'(esum_reg);
                st_next = S_A2;
            end
            S_A2:
            begin
                mac_ctl.acc_op = bcp_pkg::ACC_ADD;
                st_next        = S_V;
            end
            S_V:
            begin
                if (vt_w > V_HI)
                    v_next = bcp_pkg::CNT_W'(V_HI);
                else if (vt_w < V_LO)
                    v_next = bcp_pkg::CNT_W'(V_LO);
                else
                    v_next = bcp_pkg::CNT_W'(vt_w);
                st_next = S_DIFF;
            end
            S_DIFF:
            begin
                diff_next = DIFF_W'(roll_reg) - DIFF_W'(regs.balance_angle)
                          - (DIFF_W'(v_reg) <<< 8);
                st_next   = S_M3;
            end
            S_M3:
            begin
                mac_ctl.mul_en = 1'b1;
                op_a           = regs.upright_kp;
                op_b           = diff_reg;
                st_next        = S_M4;
            end
            S_M4:
            begin
                mac_ctl = '{mul_en: 1'b1, acc_op: bcp_pkg::ACC_LOAD};
                op_a    = regs.upright_kd;
                op_b    = bcp_pkg::MB_W'(rtilt_reg);
                st_next = S_A4;
            end
            S_A4:
            begin
                mac_ctl.acc_op = bcp_pkg::ACC_ADD_SH8;
                st_next        = S_UP;
            end
            S_UP:
            begin
                up_next        = UP_W'(trunc_shr(acc, 5'd24));
                mac_ctl.mul_en = 1'b1;
                op_a           = regs.turn_kp;
                op_b           = bcp_pkg::MB_W'(tgoal_reg);
                st_next        = S_M6;
            end
            S_M6:
            begin
                mac_ctl = '{mul_en: 1'b1, acc_op: bcp_pkg::ACC_LOAD};
                op_a    = regs.turn_kd;
                op_b    = bcp_pkg::MB_W'(ryaw_reg);
                st_next = S_A6;
            end
            S_A6:
            begin
                mac_ctl.acc_op = bcp_pkg::ACC_ADD;
                st_next        = S_TN;
            end
            S_TN:
            begin
                tn_next = UP_W'(vt_w);
                st_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    dl_next = sat_drive(SAT_W'(up_reg) - SAT_W'(tn_reg), lim_w);
                    dr_next = sat_drive(SAT_W'(up_reg) + SAT_W'(tn_reg), lim_w);
                    ov_next = 1'b1;
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            cl_reg    <= '0;
            cr_reg    <= '0;
            roll_reg  <= '0;
            rtilt_reg <= '0;
            ryaw_reg  <= '0;
            sgoal_reg <= '0;
            tgoal_reg <= '0;
            fe_reg    <= '0;
            esum_reg  <= '0;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            v_reg     <= '0;
            diff_reg  <= '0;
            up_reg    <= '0;
            tn_reg    <= '0;
            dl_reg    <= '0;
            dr_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            cl_reg    <= cl_next;
            cr_reg    <= cr_next;
            roll_reg  <= roll_next;
            rtilt_reg <= rtilt_next;
            ryaw_reg  <= ryaw_next;
            sgoal_reg <= sgoal_next;
            tgoal_reg <= tgoal_next;
            fe_reg    <= fe_next;
            esum_reg  <= esum_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            v_reg     <= v_next;
            diff_reg  <= diff_next;
            up_reg    <= up_next;
            tn_reg    <= tn_next;
            dl_reg    <= dl_next;
            dr_reg    <= dr_next;
            ov_reg    <= ov_next;
        end
    end

    `BCP_ASSERT(a_busy_after_accept, clk, rst_n, sensor.valid && sensor.ready |=> !sensor.ready)
    `BCP_ASSERT(a_sum_clamped, clk, rst_n, (SUMX_W'(esum_reg) <= ES_HI) && (SUMX_W'(esum_reg) >= ES_LO))
    `BCP_ASSERT_ALWAYS(a_fe_bounded, clk, (fe_reg <= FE_HI) && (fe_reg >= -FE_HI))
    `BCP_ASSERT(a_drive_in_limit, clk, rst_n, (st_reg == S_OUT) && out_free |=> (dl_reg <= $past(lim16_w)) && (dl_reg >= -$past(lim16_w)) && (dr_reg <= $past(lim16_w)) && (dr_reg >= -$past(lim16_w)))

endmodule

/* verif/balance_cascade_pid_step_core_tb.sv */
module balance_cascade_pid_step_core_tb;

    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASE_TICKS = 170;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [bcp_pkg::CNT_W-1:0] count_left;
        logic signed [bcp_pkg::CNT_W-1:0] count_right;
        logic signed [bcp_pkg::ANG_W-1:0] roll_angle;
        logic signed [bcp_pkg::CNT_W-1:0] rate_tilt;
        logic signed [bcp_pkg::CNT_W-1:0] rate_yaw;
        logic signed [bcp_pkg::CNT_W-1:0] speed_goal;
        logic signed [bcp_pkg::CNT_W-1:0] turn_goal;
    } tick_t;

    typedef struct packed {
        logic signed [bcp_pkg::DRV_W-1:0] left;
        logic signed [bcp_pkg::DRV_W-1:0] right;
    } drive_t;

    class drive_scoreboard;
        bcp_pkg::cfg_t regs;
        longint        filt_err;
        longint        err_sum;
        drive_t        pending[$];
        int            mismatches;

        function new();
            regs       = bcp_pkg::CFG_RESET;
            filt_err   = 0;
            err_sum    = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [bcp_pkg::CFG_IDX_W-1:0] idx,
                                logic [bcp_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                bcp_pkg::REG_UPRIGHT_KP:    regs.upright_kp    = data;
                bcp_pkg::REG_UPRIGHT_KD:    regs.upright_kd    = data;
                bcp_pkg::REG_SPEED_KP:      regs.speed_kp      = data;
                bcp_pkg::REG_SPEED_KI:      regs.speed_ki      = data;
                bcp_pkg::REG_TURN_KP:       regs.turn_kp       = data;
                bcp_pkg::REG_TURN_KD:       regs.turn_kd       = data;
                bcp_pkg::REG_BALANCE_ANGLE:
                    regs.balance_angle = data[bcp_pkg::ANG_W-1:0];
                bcp_pkg::REG_DRIVE_LIMIT:
                    regs.drive_limit = data[bcp_pkg::LIM_W-1:0];
                default: ;
            endcase
        endfunction

        // one control tick: speed PI -> upright PD setpoint, turn PD split
        function void note_tick(tick_t t);
            longint err;
            longint speed;
            longint diff;
            longint upright;
            longint turn;
            longint lim;
            longint lft;
            longint rgt;
            drive_t want;
            err = longint'(t.count_left) + longint'(t.count_right)
                - longint'(t.speed_goal);
            filt_err = (3 * err + 7 * filt_err) / 10;
            err_sum = err_sum + filt_err;
            err_sum = err_sum > bcp_pkg::SUM_CLAMP ? bcp_pkg::SUM_CLAMP
                    : (err_sum < -bcp_pkg::SUM_CLAMP ? -bcp_pkg::SUM_CLAMP : err_sum);
            speed = (longint'(regs.speed_kp) * filt_err + longint'(regs.speed_ki) * err_sum)
                    / 65536;
            speed = speed > bcp_pkg::SPEED_LIM ? bcp_pkg::SPEED_LIM
                  : (speed < -bcp_pkg::SPEED_LIM ? -bcp_pkg::SPEED_LIM : speed);
            diff = longint'(t.roll_angle) - longint'(regs.balance_angle) - speed * 256;
            upright = (longint'(regs.upright_kp) * diff
                       + longint'(regs.upright_kd) * longint'(t.rate_tilt) * 256) / 16777216;
            turn = (longint'(regs.turn_kp) * longint'(t.turn_goal)
                    + longint'(regs.turn_kd) * longint'(t.rate_yaw)) / 65536;
            lim = longint'(regs.drive_limit);
            lft = upright - turn;
            rgt = upright + turn;
            lft = lft > lim ? lim : (lft < -lim ? -lim : lft);
            rgt = rgt > lim ? lim : (rgt < -lim ? -lim : rgt);
            want.left  = lft[bcp_pkg::DRV_W-1:0];
            want.right = rgt[bcp_pkg::DRV_W-1:0];
            pending.push_back(want);
        endfunction

        function void check_drive(drive_t got);
            drive_t want;
            if (pending.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected drive request: left %0d right %0d",
                             got.left, got.right);
                mismatches++;
            end
            else
            begin
                want = pending.pop_front();
                if (got.left !== want.left || got.right !== want.right)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("drive mismatch: left exp %0d got %0d, right exp %0d got %0d",
                                 want.left, got.left, want.right, got.right);
                    mismatches++;
                end
            end
        endfunction

        function void close_out();
            if (pending.size() != 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0d drive requests never arrived", pending.size());
                mismatches += pending.size();
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   no_idle;
    int   idle_cycles = 0;

    bcp_in_if  sensor();
    bcp_out_if motor();
    bcp_cfg_if cfg_bus();

    drive_scoreboard sb = new();

    balance_cascade_pid_step_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sensor (sensor),
        .motor  (motor),
        .cfg    (cfg_bus)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
                sb.write_reg(cfg_bus.index, cfg_bus.data);
            if (motor.valid && motor.ready)
                sb.check_drive('{left: motor.drive_left, right: motor.drive_right});
            if (sensor.valid && sensor.ready)
                sb.note_tick('{count_left: sensor.count_left, count_right: sensor.count_right,
                               roll_angle: sensor.roll_angle, rate_tilt: sensor.rate_tilt,
                               rate_yaw: sensor.rate_yaw, speed_goal: sensor.speed_goal,
                               turn_goal: sensor.turn_goal});
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sensor.valid && sensor.ready) || (motor.valid && motor.ready)
                || (cfg_bus.valid && cfg_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // drive-side backpressure in short bursts
    initial
    begin
        int hold;
        hold = 0;
        motor.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (no_idle)
                motor.ready <= 1'b1;
            else if (hold > 0)
            begin
                hold--;
                motor.ready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(0, 3);
                motor.ready <= 1'b0;
            end
            else
                motor.ready <= 1'b1;
        end
    end

    function automatic int spread(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic tick_t mk_tick(input int cl, input int cr, input int roll,
                                      input int rt, input int ry, input int sg,
                                      input int tg);
        tick_t t;
        t.count_left  = bcp_pkg::CNT_W'(cl);
        t.count_right = bcp_pkg::CNT_W'(cr);
        t.roll_angle  = bcp_pkg::ANG_W'(roll);
        t.rate_tilt   = bcp_pkg::CNT_W'(rt);
        t.rate_yaw    = bcp_pkg::CNT_W'(ry);
        t.speed_goal  = bcp_pkg::CNT_W'(sg);
        t.turn_goal   = bcp_pkg::CNT_W'(tg);
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            sensor.valid <= 1'b0;
            // half the gaps start once the core is idle again
            if ($urandom_range(0, 1) == 0)
                do @(posedge clk); while (!sensor.ready);
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        sensor.valid       <= 1'b1;
        sensor.count_left  <= t.count_left;
        sensor.count_right <= t.count_right;
        sensor.roll_angle  <= t.roll_angle;
        sensor.rate_tilt   <= t.rate_tilt;
        sensor.rate_yaw    <= t.rate_yaw;
        sensor.speed_goal  <= t.speed_goal;
        sensor.turn_goal   <= t.turn_goal;
        do @(posedge clk); while (!sensor.ready);
    endtask

    task automatic drain();
        sensor.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_one(input logic [bcp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bcp_pkg::CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge clk); while (!cfg_bus.ready);
    endtask

    task automatic program_regs(input logic [31:0] ukp, ukd, skp, ski, tkp, tkd, bal, lim);
        write_one(bcp_pkg::REG_UPRIGHT_KP, ukp);
        write_one(bcp_pkg::REG_UPRIGHT_KD, ukd);
        write_one(bcp_pkg::REG_SPEED_KP, skp);
        write_one(bcp_pkg::REG_SPEED_KI, ski);
        write_one(bcp_pkg::REG_TURN_KP, tkp);
        write_one(bcp_pkg::REG_TURN_KD, tkd);
        write_one(bcp_pkg::REG_BALANCE_ANGLE, bal);
        write_one(bcp_pkg::REG_DRIVE_LIMIT, lim);
        cfg_bus.valid <= 1'b0;
    endtask

    // runs of same-sign wheel speed drive the integral into its clamp
    task automatic run_phase(input int n);
        tick_t        t;
        logic [127:0] raw;
        int           push;
        int           base;
        push = 0;
        for (int k = 0; k < n; k++)
        begin
            if (k % 25 == 0)
                push = int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 9) < 3)
            begin
                raw = {$urandom, $urandom, $urandom, $urandom};
                t   = tick_t'(raw[$bits(tick_t)-1:0]);
            end
            else
            begin
                base = push * int'($urandom_range(2000, 16000));
                t    = mk_tick(base + spread(100), base + spread(100), spread(46080),
                               spread(4000), spread(4000), spread(300), spread(200));
            end
            send_tick(t);
        end
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        no_idle             <= 1'b0;
        sensor.valid        <= 1'b0;
        sensor.count_left   <= '0;
        sensor.count_right  <= '0;
        sensor.roll_angle   <= '0;
        sensor.rate_tilt    <= '0;
        sensor.rate_yaw     <= '0;
        sensor.speed_goal   <= '0;
        sensor.turn_goal    <= '0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= bcp_pkg::REG_UPRIGHT_KP;
        cfg_bus.data        <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // field extremes and integral clamp both ways
        send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0));
        send_tick(mk_tick(32767, 32767, 46080, 32767, 32767, -32768, 32767));
        send_tick(mk_tick(32767, 32767, 46080, 32767, 32767, -32768, 32767));
        send_tick(mk_tick(32767, 32767, 46080, 32767, 32767, -32768, 32767));
        send_tick(mk_tick(-32768, -32768, -46080, -32768, -32768, 32767, -32768));
        send_tick(mk_tick(-32768, -32768, -46080, -32768, -32768, 32767, -32768));
        send_tick(mk_tick(-32768, -32768, -46080, -32768, -32768, 32767, -32768));
        send_tick(mk_tick(-32768, -32768, -46080, -32768, -32768, 32767, -32768));
        send_tick(mk_tick(0, 0, 65535, 0, 0, 0, 0));
        send_tick(mk_tick(0, 0, -65536, 0, 0, 0, 0));
        send_tick(mk_tick(0, 0, 0, 32767, 0, 0, 0));
        send_tick(mk_tick(0, 0, 0, -32768, 0, 0, 0));
        send_tick(mk_tick(0, 0, 0, 0, 32767, 0, -32768));
        send_tick(mk_tick(0, 0, 0, 0, -32768, 0, 32767));
        send_tick(mk_tick(10, 12, -1536, 100, -50, 20, 5));
        drain();

        run_phase(PHASE_TICKS);
        drain();

        program_regs($urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
        run_phase(PHASE_TICKS);
        drain();

        program_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_ffff, 32'hffff_ffff);
        run_phase(PHASE_TICKS);
        drain();

        // most negative gains, angle below range, zero drive limit
        program_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'hffff_0000, 32'h0000_8000);
        run_phase(PHASE_TICKS);
        drain();

        program_regs(bcp_pkg::CFG_RESET.upright_kp + spread(1 << 20),
                     bcp_pkg::CFG_RESET.upright_kd + spread(1 << 16),
                     bcp_pkg::CFG_RESET.speed_kp + spread(1 << 14),
                     bcp_pkg::CFG_RESET.speed_ki + spread(1 << 8),
                     bcp_pkg::CFG_RESET.turn_kp + spread(1 << 20),
                     bcp_pkg::CFG_RESET.turn_kd + spread(1 << 16),
                     spread(46080), $urandom_range(0, 32767));
        run_phase(PHASE_TICKS);
        drain();

        program_regs($urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, 32'h0000_7fff);
        run_phase(PHASE_TICKS);
        drain();

        no_idle <= 1'b1;
        program_regs(bcp_pkg::CFG_RESET.upright_kp, bcp_pkg::CFG_RESET.upright_kd,
                     bcp_pkg::CFG_RESET.speed_kp, bcp_pkg::CFG_RESET.speed_ki,
                     bcp_pkg::CFG_RESET.turn_kp, bcp_pkg::CFG_RESET.turn_kd,
                     32'(bcp_pkg::CFG_RESET.balance_angle),
                     32'(bcp_pkg::CFG_RESET.drive_limit));
        run_phase(PHASE_TICKS);
        drain();

        repeat (40) @(posedge clk);
        sb.close_out();
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* balance_cascade_pid_step_core.f */
+incdir+rtl/core
rtl/core/bcp_pkg.sv
rtl/core/bcp_if.sv
rtl/core/bcp_cfg_regs.sv
rtl/core/bcp_mac.sv
rtl/core/balance_cascade_pid_step_core.sv
verif/balance_cascade_pid_step_core_tb.sv
